### sv/scbp_pkg.sv
// Shared types, constants and the class capacity table for the size class buffer pool.
package scbp_pkg;

    localparam int MAX_CLASSES = 64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RECYCLE = 1'b1;

    localparam logic [15:0] USE_MAX = 16'hFFFF;

    typedef logic [31:0] t_cap_table [0:MAX_CLASSES-1];

    typedef struct packed {
        logic       done;
        logic       found;
        logic [5:0] cls;
    } t_search_rsp;

    function automatic t_cap_table build_cap_table();
        t_cap_table     tbl;
        longint unsigned s;
        longint unsigned c;
        longint unsigned a;
        longint unsigned b;
        s = 64'd1;
        for (int i = 0; i < MAX_CLASSES; i++) begin
            c = s * 64'd4;
            tbl[i] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
            a = s + 64'd1;
            b = s + (s >> 1);
            s = (a > b) ? a : b;
            if (s > 64'hFFFF_FFFF) begin
                s = 64'hFFFF_FFFF;
            end
        end
        return tbl;
    endfunction

    localparam t_cap_table CLASS_CAP = build_cap_table();

endpackage

### sv/scbp_if.sv
// Request and response channel interfaces of the size class buffer pool.
interface scbp_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] req_size;
    logic [15:0] buf_handle;
    logic [31:0] buf_capacity;

    modport source (output valid, cmd, req_size, buf_handle, buf_capacity, input ready);
    modport sink   (input valid, cmd, req_size, buf_handle, buf_capacity, output ready);
endinterface

interface scbp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [31:0] out_capacity;
    logic        fresh;
    logic [5:0]  class_index;

    modport source (output valid, status, out_handle, out_capacity, fresh, class_index,
                    input ready);
    modport sink   (input valid, status, out_handle, out_capacity, fresh, class_index,
                    output ready);
endinterface

### sv/size_class_buffer_pool_top.sv
// Top level of the size class buffer pool: sequencer, free stacks and class bookkeeping.
//
// Requests arrive on i_req (cmd, req_size, buf_handle, buf_capacity) and one response per
// request leaves on o_rsp (status, out_handle, out_capacity, fresh, class_index). Both
// channels transfer when valid and ready are high at a rising edge of i_clk.
// A request runs a binary search with one shared comparator over the capacity table, and
// the class bookkeeping is read as the search settles; the sequencer then acts on it, does
// a free stack read on an allocate that reuses a handle, and loads the response register.
// i_req.ready is high only while the sequencer is idle, so one request is in work at a time.
// The response sits in an output register; a new request is taken while it waits, and the
// sequencer holds its next result until the receiver takes the previous one.
// Synchronous active-low reset empties all free stacks, clears the use counts and the
// fresh handle counter, and drops any pending response. No clearing pass is needed.
module size_class_buffer_pool_top
    import scbp_pkg::*;
#(
    parameter int NUM_CLASSES = 48,
    parameter int STACK_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scbp_req_if.sink   i_req,
    scbp_rsp_if.source o_rsp
);

    localparam int TW    = $clog2(STACK_DEPTH + 1);
    localparam int KW    = $clog2(NUM_CLASSES);
    localparam int NENT  = NUM_CLASSES * STACK_DEPTH;
    localparam int AW    = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int MW    = TW + 16;
    localparam logic [AW-1:0] DEPTH_A = AW'(STACK_DEPTH);
    localparam logic [TW-1:0] DEPTH_T = TW'(STACK_DEPTH);
    localparam logic [15:0] HMASK = (HANDLE_BITS >= 16) ? 16'hFFFF :
                                    16'((32'd1 << HANDLE_BITS) - 32'd1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_META   = 3'd2;
    localparam logic [2:0] S_POP    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  n_state;

    logic        r_cmd;
    logic [15:0] r_handle_in;
    logic [5:0]  r_cls;
    logic [1:0]  r_status;
    logic [15:0] r_handle;
    logic        r_fresh;
    logic [HANDLE_BITS:0] r_next;

    logic        r_o_vld;
    logic [1:0]  r_o_status;
    logic [15:0] r_o_handle;
    logic [31:0] r_o_cap;
    logic        r_o_fresh;
    logic [5:0]  r_o_cls;

    logic [15:0] r_stack_mem [0:NENT-1];
    logic [15:0] r_stack_rd;
    logic [MW-1:0] r_meta_mem [0:NUM_CLASSES-1];
    logic [MW-1:0] r_meta_rd;
    logic        r_meta_rv;
    logic [NUM_CLASSES-1:0] r_meta_vld;

    logic        w_accept;
    logic        w_start;
    logic [31:0] w_size;
    t_search_rsp w_srch;

    logic [KW-1:0] w_kidx;
    logic [MW-1:0] w_meta;
    logic [TW-1:0] w_top;
    logic [15:0]   w_use;
    logic [15:0]   w_use_inc;
    logic [15:0]   w_use_dec;
    logic [TW-1:0] w_top_m1;

    logic          w_meta_we;
    logic [MW-1:0] w_meta_wd;
    logic          w_stack_we;
    logic          w_stack_re;
    logic [TW-1:0] w_stack_t;
    logic [AW-1:0] w_stack_addr;
    logic          w_fresh_take;
    logic          w_out_free;
    logic [HANDLE_BITS+16:0] w_next_ext;
    logic [31:0]   w_cls_cap;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_start     = w_accept;
    assign w_size      = (i_req.cmd == CMD_RECYCLE) ? i_req.buf_capacity : i_req.req_size;

    scbp_class_search #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_size  (w_size),
        .o_rsp   (w_srch)
    );

    assign w_kidx     = (r_state == S_SEARCH) ? w_srch.cls[KW-1:0] : r_cls[KW-1:0];
    assign w_meta     = r_meta_rv ? r_meta_rd : '0;
    assign w_top      = w_meta[MW-1:16];
    assign w_use      = w_meta[15:0];
    assign w_use_inc  = (w_use == USE_MAX) ? w_use : w_use + 16'd1;
    assign w_use_dec  = (w_use == 16'd0) ? w_use : w_use - 16'd1;
    assign w_top_m1   = w_top - TW'(1);
    assign w_out_free = !r_o_vld || o_rsp.ready;
    assign w_next_ext = {16'b0, r_next};
    assign w_cls_cap  = CLASS_CAP[r_cls];

    always_comb begin
        n_state      = r_state;
        w_meta_we    = 1'b0;
        w_meta_wd    = w_meta;
        w_stack_we   = 1'b0;
        w_stack_re   = 1'b0;
        w_stack_t    = w_top;
        w_fresh_take = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_srch.done) begin
                    n_state = w_srch.found ? S_META : S_FIN;
                end
            end
            S_META: begin
                n_state = S_FIN;
                if (r_cmd == CMD_ALLOC) begin
                    if (w_top != '0) begin
                        w_stack_re = 1'b1;
                        w_stack_t  = w_top_m1;
                        n_state    = S_POP;
                    end else if (!r_next[HANDLE_BITS]) begin
                        w_fresh_take = 1'b1;
                        w_meta_we    = 1'b1;
                        w_meta_wd    = {w_top, w_use_inc};
                    end
                end else if (w_top < DEPTH_T) begin
                    w_stack_we = 1'b1;
                    w_meta_we  = 1'b1;
                    w_meta_wd  = {w_top + TW'(1), w_use_dec};
                end
            end
            S_POP: begin
                w_meta_we = 1'b1;
                w_meta_wd = {w_top_m1, w_use_inc};
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_stack_addr = AW'(r_cls) * DEPTH_A + AW'(w_stack_t);

    always_ff @(posedge i_clk) begin
        if (w_stack_we) begin
            r_stack_mem[w_stack_addr] <= r_handle_in & HMASK;
        end
        if (w_stack_re) begin
            r_stack_rd <= r_stack_mem[w_stack_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_meta_we) begin
            r_meta_mem[w_kidx] <= w_meta_wd;
        end
        if (r_state == S_SEARCH) begin
            r_meta_rd <= r_meta_mem[w_kidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_meta_vld <= '0;
            r_meta_rv  <= 1'b0;
            r_next     <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_meta_we) begin
                r_meta_vld[w_kidx] <= 1'b1;
            end
            if (r_state == S_SEARCH) begin
                r_meta_rv <= r_meta_vld[w_kidx];
            end
            if (w_fresh_take) begin
                r_next <= r_next + (HANDLE_BITS + 1)'(1);
            end
            if (r_state == S_FIN && w_out_free) begin
                r_o_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= i_req.cmd;
            r_handle_in <= i_req.buf_handle;
        end
        case (r_state)
            S_SEARCH: begin
                if (w_srch.done) begin
                    r_cls    <= w_srch.cls;
                    r_status <= ST_TOO_LARGE;
                    r_handle <= '0;
                    r_fresh  <= 1'b0;
                end
            end
            S_META: begin
                r_status <= ST_OK;
                if (r_cmd == CMD_ALLOC) begin
                    if (w_top == '0) begin
                        if (r_next[HANDLE_BITS]) begin
                            r_status <= ST_EXHAUSTED;
                        end else begin
                            r_handle <= w_next_ext[15:0];
                            r_fresh  <= 1'b1;
                        end
                    end
                end else if (w_top >= DEPTH_T) begin
                    r_status <= ST_FULL;
                end
            end
            S_POP: begin
                r_handle <= r_stack_rd;
            end
            default: begin
            end
        endcase
        if (r_state == S_FIN && w_out_free) begin
            r_o_status <= r_status;
            r_o_handle <= r_handle;
            r_o_fresh  <= r_fresh;
            r_o_cls    <= (r_status == ST_TOO_LARGE) ? 6'd0 : r_cls;
            r_o_cap    <= (r_status == ST_TOO_LARGE) ? 32'd0 : w_cls_cap;
        end
    end

    assign o_rsp.valid        = r_o_vld;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.out_handle   = r_o_handle;
    assign o_rsp.out_capacity = r_o_cap;
    assign o_rsp.fresh        = r_o_fresh;
    assign o_rsp.class_index  = r_o_cls;

endmodule

### sv/scbp_class_search.sv
// Iterative binary search of the class capacity table with one shared comparator.
module scbp_class_search
    import scbp_pkg::*;
#(
    parameter int NUM_CLASSES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_size,
    output t_search_rsp o_rsp
);

    localparam int CW = $clog2(NUM_CLASSES + 1);

    logic          r_busy;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [31:0]   r_size;

    logic          w_more;
    logic [CW-1:0] w_mid;
    logic [CW+5:0] w_mid_ext;
    logic [CW+5:0] w_lo_ext;
    logic [31:0]   w_cap;
    logic          w_below;

    assign w_more    = r_lo < r_hi;
    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_mid_ext = {6'b0, w_mid};
    assign w_lo_ext  = {6'b0, r_lo};
    assign w_cap     = CLASS_CAP[w_mid_ext[5:0]];
    assign w_below   = w_cap < r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && !w_more) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo   <= '0;
            r_hi   <= CW'(NUM_CLASSES);
            r_size <= i_size;
        end else if (r_busy && w_more) begin
            if (w_below) begin
                r_lo <= w_mid + CW'(1);
            end else begin
                r_hi <= w_mid;
            end
        end
    end

    assign o_rsp.done  = r_busy && !w_more;
    assign o_rsp.found = r_lo < CW'(NUM_CLASSES);
    assign o_rsp.cls   = w_lo_ext[5:0];

endmodule

### tb/tb_size_class_buffer_pool_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the size class buffer pool: directed table and random traffic.
module tb_size_class_buffer_pool_top
    import scbp_pkg::*;
;

    localparam int NUM_CLS      = 48;
    localparam int STK_DEPTH    = 16;
    localparam int HANDLE_W     = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [31:0] capacity;
        logic        fresh;
        logic [5:0]  cls;
    } t_pool_rsp;

    typedef struct {
        logic        cmd;
        logic [31:0] req_size;
        logic [15:0] buf_handle;
        logic [31:0] buf_capacity;
        bit          typed;
        t_pool_rsp   rsp;
    } t_stim_row;

    typedef struct {
        logic [15:0] handle;
        int unsigned cls;
    } t_held_buf;

    logic i_clk = 1'b0;
    logic i_rst_n;

    scbp_req_if req_ch ();
    scbp_rsp_if rsp_ch ();

    size_class_buffer_pool_top #(
        .NUM_CLASSES(NUM_CLS),
        .STACK_DEPTH(STK_DEPTH),
        .HANDLE_BITS(HANDLE_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    logic [31:0] class_cap [NUM_CLS];
    logic [15:0] free_list [NUM_CLS][STK_DEPTH];
    int unsigned free_top  [NUM_CLS];
    logic [15:0] class_use [NUM_CLS];
    int unsigned fresh_next;

    t_pool_rsp   pending_responses [$];
    t_held_buf   held_bufs [$];
    t_stim_row   directed_rows [$];

    int unsigned mismatch_count;
    int unsigned transfer_count;
    int unsigned status_seen [4];
    bit          idle_on;
    bit          hold_request;

    task automatic build_class_caps();
        longint unsigned s;
        longint unsigned c;
        s = 1;
        for (int i = 0; i < NUM_CLS; i++) begin
            c = s * 4;
            class_cap[i] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
            s += (s < 2) ? 1 : s / 2;
            if (s > 64'hFFFF_FFFF) begin
                s = 64'hFFFF_FFFF;
            end
        end
        for (int i = 0; i < NUM_CLS; i++) begin
            free_top[i]  = 0;
            class_use[i] = '0;
        end
        fresh_next = 0;
    endtask

    function automatic int unsigned class_for_size(logic [31:0] size);
        for (int k = 0; k < NUM_CLS; k++) begin
            if (class_cap[k] >= size) begin
                return k;
            end
        end
        return NUM_CLS;
    endfunction

    function automatic logic [31:0] size_in_class(int unsigned k);
        logic [31:0] lo;
        lo = (k == 0) ? 32'd0 : class_cap[k-1] + 32'd1;
        return $urandom_range(class_cap[k], lo);
    endfunction

    function automatic t_pool_rsp pool_predict(logic cmd, logic [31:0] size,
                                               logic [15:0] handle, logic [31:0] capacity);
        t_pool_rsp   r;
        int unsigned k;
        r = '0;
        k = class_for_size((cmd == CMD_ALLOC) ? size : capacity);
        if (k >= NUM_CLS) begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        r.capacity = class_cap[k];
        r.cls      = 6'(k);
        if (cmd == CMD_ALLOC) begin
            if (free_top[k] > 0) begin
                free_top[k]--;
                r.handle = free_list[k][free_top[k]];
            end else if (fresh_next >= (1 << HANDLE_W)) begin
                r.status = ST_EXHAUSTED;
                return r;
            end else begin
                r.handle = 16'(fresh_next);
                r.fresh  = 1'b1;
                fresh_next++;
            end
            if (class_use[k] != USE_MAX) begin
                class_use[k]++;
            end
        end else begin
            if (free_top[k] >= STK_DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            free_list[k][free_top[k]] = handle;
            free_top[k]++;
            if (class_use[k] != 16'd0) begin
                class_use[k]--;
            end
        end
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_pool_rsp grant(logic [1:0] status, logic [15:0] handle,
                                        logic [31:0] capacity, logic fresh, logic [5:0] cls);
        t_pool_rsp r;
        r.status   = status;
        r.handle   = handle;
        r.capacity = capacity;
        r.fresh    = fresh;
        r.cls      = cls;
        return r;
    endfunction

    function automatic t_stim_row make_row(logic cmd, logic [31:0] size, logic [15:0] handle,
                                           logic [31:0] capacity, bit typed, t_pool_rsp rsp);
        t_stim_row row;
        row.cmd          = cmd;
        row.req_size     = size;
        row.buf_handle   = handle;
        row.buf_capacity = capacity;
        row.typed        = typed;
        row.rsp          = rsp;
        return row;
    endfunction

    task automatic add_row(t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 60);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_row(t_stim_row row);
        t_pool_rsp r;
        t_held_buf hb;
        req_ch.valid        <= 1'b1;
        req_ch.cmd          <= row.cmd;
        req_ch.req_size     <= row.req_size;
        req_ch.buf_handle   <= row.buf_handle;
        req_ch.buf_capacity <= row.buf_capacity;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        r = pool_predict(row.cmd, row.req_size, row.buf_handle, row.buf_capacity);
        pending_responses.insert(pending_responses.size(), row.typed ? row.rsp : r);
        if (row.cmd == CMD_ALLOC && r.status == ST_OK && held_bufs.size() < 4096) begin
            hb.handle = r.handle;
            hb.cls    = 32'(r.cls);
            held_bufs.insert(held_bufs.size(), hb);
        end
        transfer_count++;
    endtask

    task automatic idle_gap();
        int unsigned n;
        n = idle_on ? pick_gap() : 0;
        if (n > 0) begin
            req_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_plain(logic cmd, logic [31:0] size, logic [15:0] handle,
                              logic [31:0] capacity);
        send_row(make_row(cmd, size, handle, capacity, 1'b0, '0));
        idle_gap();
    endtask

    task automatic send_well_formed();
        int unsigned idx;
        int unsigned k;
        t_held_buf   hb;
        if (held_bufs.size() != 0 && $urandom_range(0, 1) == 1) begin
            idx = $urandom_range(0, held_bufs.size() - 1);
            hb  = held_bufs[idx];
            held_bufs.delete(idx);
            send_plain(CMD_RECYCLE, $urandom, hb.handle, size_in_class(hb.cls));
        end else begin
            k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, NUM_CLS - 1);
            send_plain(CMD_ALLOC, size_in_class(k), 16'($urandom), $urandom);
        end
    endtask

    // Response side: random stalls, plus a long hold-off each time one is requested.
    initial begin
        int unsigned n;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                rsp_ch.ready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 9) < 3) begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pool_rsp want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with none outstanding", 32'(rsp_ch.status), 32'd0);
            end else begin
                want = pending_responses.pop_front();
                status_seen[rsp_ch.status]++;
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.out_handle !== want.handle)
                    report_mismatch("out_handle", 32'(rsp_ch.out_handle), 32'(want.handle));
                if (rsp_ch.out_capacity !== want.capacity)
                    report_mismatch("out_capacity", rsp_ch.out_capacity, want.capacity);
                if (rsp_ch.fresh !== want.fresh)
                    report_mismatch("fresh", 32'(rsp_ch.fresh), 32'(want.fresh));
                if (rsp_ch.class_index !== want.cls)
                    report_mismatch("class_index", 32'(rsp_ch.class_index), 32'(want.cls));
            end
        end
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int unsigned random_sent;
        int unsigned batch;
        int unsigned mode;
        int unsigned k;
        t_pool_rsp   none;

        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_ALLOC;
        req_ch.req_size     <= '0;
        req_ch.buf_handle   <= '0;
        req_ch.buf_capacity <= '0;
        mismatch_count = 0;
        transfer_count = 0;
        for (int i = 0; i < 4; i++) status_seen[i] = 0;
        idle_on      = 1'b0;
        hold_request = 1'b0;
        none         = '0;
        build_class_caps();

        add_row(make_row(CMD_ALLOC, 32'd0, 16'h0000, 32'd0, 1'b1,
                         grant(ST_OK, 16'd0, 32'd4, 1'b1, 6'd0)));
        add_row(make_row(CMD_ALLOC, 32'd5, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
                         grant(ST_OK, 16'd1, 32'd8, 1'b1, 6'd1)));
        add_row(make_row(CMD_ALLOC, 32'hFFFF_FFFF, 16'h0000, 32'd0, 1'b1,
                         grant(ST_TOO_LARGE, 16'd0, 32'd0, 1'b0, 6'd0)));
        add_row(make_row(CMD_RECYCLE, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b1,
                         grant(ST_OK, 16'd0, 32'd4, 1'b0, 6'd0)));
        add_row(make_row(CMD_ALLOC, 32'd1, 16'h0000, 32'd0, 1'b1,
                         grant(ST_OK, 16'hFFFF, 32'd4, 1'b0, 6'd0)));
        add_row(make_row(CMD_RECYCLE, 32'd0, 16'h5A5A, 32'hFFFF_FFFF, 1'b1,
                         grant(ST_TOO_LARGE, 16'd0, 32'd0, 1'b0, 6'd0)));
        add_row(make_row(CMD_ALLOC, class_cap[NUM_CLS-1], 16'h0, 32'd0, 1'b0, none));
        add_row(make_row(CMD_ALLOC, class_cap[NUM_CLS-1] + 32'd1, 16'h0, 32'd0,
                         1'b1, grant(ST_TOO_LARGE, 16'd0, 32'd0, 1'b0, 6'd0)));
        for (int i = 0; i < STK_DEPTH + 1; i++) begin
            add_row(make_row(CMD_RECYCLE, 32'd0, 16'h1000 + 16'(i) * 16'h0EEF,
                32'd9 + 32'(i % 4), 1'b1,
                grant((i < STK_DEPTH) ? ST_OK : ST_FULL, 16'd0, 32'd12, 1'b0, 6'd2)));
        end
        add_row(make_row(CMD_ALLOC, 32'd12, 16'h0, 32'd0, 1'b0, none));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_row(directed_rows[i]);
        end

        random_sent = 0;
        batch       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (batch == 6 || batch == 31) begin
                idle_on      = 1'b0;
                hold_request = 1'b1;
            end
            if (batch == 14 || batch == 40) begin
                drain_responses();
            end
            mode = $urandom_range(0, 9);
            k    = $urandom_range(0, 7);
            for (int j = 0; j < 20; j++) begin
                if (mode < 6) begin
                    send_well_formed();
                end else if (mode < 8) begin
                    send_plain(CMD_RECYCLE, $urandom, 16'($urandom), size_in_class(k));
                end else begin
                    send_plain(1'($urandom_range(0, 1)), $urandom >> $urandom_range(0, 31),
                               16'($urandom), $urandom >> $urandom_range(0, 31));
                end
                random_sent++;
            end
            batch++;
        end

        idle_on = 1'b1;
        for (int j = 0; j < 30; j++) begin
            send_well_formed();
        end

        drain_responses();
        repeat (40) @(posedge i_clk);

        while (pending_responses.size() != 0) begin
            report_mismatch("response never arrived", 32'd0, 32'(pending_responses[0].status));
            void'(pending_responses.pop_front());
        end

        $display("Run covered %0d transfers and issued %0d fresh handles.",
                 transfer_count, fresh_next);
        $display("Status mix: ok %0d, too large %0d, stack full %0d, exhausted %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### size_class_buffer_pool_top.f
sv/scbp_pkg.sv
sv/scbp_if.sv
sv/scbp_class_search.sv
sv/size_class_buffer_pool_top.sv
tb/tb_size_class_buffer_pool_top.sv
